// ===== rtl/assert_macros.svh =====
// Assertion macros used by the sorted list top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SLI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted list assertion failed");

// Checked on every clock edge, reset included.
`define SLI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sorted list assertion failed");

`endif

// ===== rtl/sli_pkg.sv =====
// Package for the sorted list store: widths, codes and the cell control struct.
package sli_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int VALUE_W       = 32;
  localparam int COUNT_FIELD_W = 5;
  localparam int STATUS_W      = 3;
  localparam int CMD_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE     = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_NOTFOUND = 3'd2,
    STATUS_EMPTY    = 3'd3,
    STATUS_DUMPED   = 3'd4
  } status_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ===== rtl/sli_cell.sv =====
// One slot of the sorted chain: holds a value and shifts with its neighbors.
module sli_cell #(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 5
) (
  input  logic                                clk,
  input  sli_pkg::cell_ctrl_t                 ctrl,
  input  logic [COUNT_W-1:0]                  entry_count,
  input  logic                                left_lt,
  input  logic signed [sli_pkg::VALUE_W-1:0]  left_value,
  input  logic signed [sli_pkg::VALUE_W-1:0]  right_value,
  input  logic signed [sli_pkg::VALUE_W-1:0]  head_value,
  output logic                                lt,
  output logic                                first_eq,
  output logic signed [sli_pkg::VALUE_W-1:0]  value
);
  import sli_pkg::*;

  logic occupied;
  logic is_last;

  assign occupied = COUNT_W'(INDEX) < entry_count;
  assign is_last  = COUNT_W'(INDEX + 1) == entry_count;
  assign lt       = occupied && (value < ctrl.value);
  // sorted order: first copy of the key sits right after the last smaller entry
  assign first_eq = occupied && (value == ctrl.value) && left_lt;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (!left_lt) begin
          value <= left_value;
        end else if (!lt) begin
          value <= ctrl.value;
        end
      end
      CELL_DELETE: begin
        if (!lt) begin
          value <= right_value;
        end
      end
      CELL_ROTATE: begin
        value <= is_last ? head_value : right_value;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/sorted_list_insert_delete.sv =====
// Top level of the sorted list store: cell chain, command control and output register.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells, one value per cell. Every cell compares its value with the request
// at once, so an insert or delete finishes in the cycle the transaction is
// accepted: each cell keeps its value, takes the request, or takes its left
// or right neighbor's value. Insert and delete answer with one result that
// carries the new count; the next command is taken as soon as the output
// register is free, so these run at one transaction per cycle while the
// output side keeps up. A dump first enters the dump state, then the chain
// rotates by one cell per delivered result and the head cell streams out,
// returning to its original order after the last entry. An empty dump
// gives a single empty result. Input is stalled for the whole dump. Command
// code 3 is dropped without a result. The count field is 5 bits wide and
// wraps for CAPACITY above 31.
`include "assert_macros.svh"

module sorted_list_insert_delete #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sli_pkg::CMD_W-1:0]             cmd,
  input  logic signed [sli_pkg::VALUE_W-1:0]    value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sli_pkg::STATUS_W-1:0]          status,
  output logic signed [sli_pkg::VALUE_W-1:0]    entry_value,
  output logic [sli_pkg::COUNT_FIELD_W-1:0]     count,
  output logic                                  last
);
  import sli_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [IDX_W-1:0]   dump_idx, dump_idx_next;

  // chain signals
  cell_ctrl_t                 cell_ctrl;
  logic signed [VALUE_W-1:0]  cell_value [CAPACITY];
  logic [CAPACITY-1:0]        cell_lt;
  logic [CAPACITY-1:0]        cell_first_eq;
  logic                       found;

  // output register
  logic                       out_free;
  logic                       load;
  status_t                    ld_status;
  logic signed [VALUE_W-1:0]  ld_value;
  logic [CNT_W-1:0]           ld_count;
  logic                       ld_last;
  status_t                    status_reg;
  logic [CNT_W-1:0]           count_reg;
  logic [CNT_W+COUNT_FIELD_W-1:0] count_ext;

  logic in_accept;
  logic is_full;
  logic dump_last;

  // Output slot frees when empty or when its transaction completes.
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == ST_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  assign is_full   = entry_count == CNT_W'(CAPACITY);
  assign found     = |cell_first_eq;
  assign dump_last = (CNT_W'(dump_idx) + CNT_W'(1)) == entry_count;

  // Cell row. Left edge acts as "smaller than anything"; the right edge
  // feeds back its own value since the slot beyond the end is unused.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                       left_lt;
    logic signed [VALUE_W-1:0]  left_value;
    logic signed [VALUE_W-1:0]  right_value;

    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_value = cell_value[g];
    end else begin : g_body
      assign left_lt    = cell_lt[g-1];
      assign left_value = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[g];
    end else begin : g_inner
      assign right_value = cell_value[g+1];
    end

    sli_cell #(
      .INDEX   (g),
      .COUNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .entry_count (entry_count),
      .left_lt     (left_lt),
      .left_value  (left_value),
      .right_value (right_value),
      .head_value  (cell_value[0]),
      .lt          (cell_lt[g]),
      .first_eq    (cell_first_eq[g]),
      .value       (cell_value[g])
    );
  end

  // Command decode and dump sequencing.
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    dump_idx_next    = dump_idx;
    cell_ctrl.op     = CELL_HOLD;
    cell_ctrl.value  = value;
    load             = 1'b0;
    ld_status        = STATUS_DONE;
    ld_value         = value;
    ld_count         = entry_count;
    ld_last          = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (cmd_t'(cmd))
            CMD_INSERT: begin
              load = 1'b1;
              if (is_full) begin
                ld_status = STATUS_FULL;
              end else begin
                cell_ctrl.op     = CELL_INSERT;
                entry_count_next = entry_count + CNT_W'(1);
                ld_count         = entry_count + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              load = 1'b1;
              if (entry_count == '0) begin
                ld_status = STATUS_EMPTY;
              end else if (!found) begin
                ld_status = STATUS_NOTFOUND;
              end else begin
                cell_ctrl.op     = CELL_DELETE;
                entry_count_next = entry_count - CNT_W'(1);
                ld_count         = entry_count - CNT_W'(1);
              end
            end
            CMD_DUMP: begin
              if (entry_count == '0) begin
                load      = 1'b1;
                ld_status = STATUS_EMPTY;
                ld_value  = '0;
              end else begin
                state_next    = ST_DUMP;
                dump_idx_next = '0;
              end
            end
            default: begin
              // unused command: no result
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          load         = 1'b1;
          ld_status    = STATUS_DUMPED;
          ld_value     = cell_value[0];
          ld_last      = dump_last;
          cell_ctrl.op = CELL_ROTATE;
          if (dump_last) begin
            state_next    = ST_IDLE;
            dump_idx_next = '0;
          end else begin
            dump_idx_next = dump_idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      dump_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      dump_idx    <= dump_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    if (load) begin
      status_reg  <= ld_status;
      entry_value <= ld_value;
      count_reg   <= ld_count;
      last        <= ld_last;
    end
  end

  assign status    = status_reg;
  assign count_ext = {{COUNT_FIELD_W{1'b0}}, count_reg};
  assign count     = count_ext[COUNT_FIELD_W-1:0];

  // Checks
  `SLI_ASSERT(a_count_bound, entry_count <= CNT_W'(CAPACITY))
  `SLI_ASSERT(a_dump_nonempty, (state == ST_DUMP) |-> (entry_count != '0))
  `SLI_ASSERT(a_insert_grows, (in_accept && (cmd_t'(cmd) == CMD_INSERT) && !is_full) |=> (entry_count == $past(entry_count) + CNT_W'(1)))
  `SLI_ASSERT_ALWAYS(a_reset_empty, rst |=> ((entry_count == '0) && !out_valid))

endmodule
